>>> design/imhrl_pkg.sv
// ----------------------------------------------------------------------------
// imhrl_pkg
// Shared constants, codes and types of the route limit heap.
// ----------------------------------------------------------------------------
package imhrl_pkg;

  // Sizing
  localparam int MAX_ROADS   = 64;
  localparam int HEIGHT_BITS = 16;
  localparam int ROAD_W      = 7;
  localparam int CMD_W       = 1;
  localparam int CFG_W       = 7;
  localparam int APB_DATA_W  = 32;
  localparam int PADDR_W     = 3;

  localparam int SLOT_W  = ($clog2(MAX_ROADS) < 2) ? 2 : $clog2(MAX_ROADS);
  localparam int ROW_W   = SLOT_W - 1;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int KIDX_W  = SLOT_W + 2;
  localparam int KEY_W   = HEIGHT_BITS + 1;

  localparam int COUNT_RESET = (64 > MAX_ROADS) ? MAX_ROADS : 64;

  localparam logic [KEY_W-1:0] KEY_UNLIMITED = {1'b1, {HEIGHT_BITS{1'b0}}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Register index as decoded from paddr[2]
  localparam logic REG_ROAD_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_LOOKUP,
    ST_FETCH,
    ST_KIDS,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] road;
  } heap_ent_t;

  localparam int HEAP_W = $bits(heap_ent_t);

  typedef struct packed {
    logic             reinit;
    logic [CNT_W-1:0] count;
  } cfg_t;

endpackage

>>> design/imhrl_ram.sv
// ----------------------------------------------------------------------------
// imhrl_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imhrl_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/imhrl_cfg.sv
// ----------------------------------------------------------------------------
// imhrl_cfg
// APB register file: road count, clamped on write, with reinit strobe.
// ----------------------------------------------------------------------------
module imhrl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imhrl_pkg::PADDR_W-1:0]  paddr,
  input  logic [imhrl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [imhrl_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output imhrl_pkg::cfg_t                cfg_o
);
  import imhrl_pkg::*;

  logic             wr_en;
  logic [CFG_W-1:0] wval;
  logic [CNT_W-1:0] count_q, count_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_ROAD_COUNT);
  assign wval   = pwdata[CFG_W-1:0];

  // Clamp the written count into 1..MAX_ROADS
  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      if (wval == '0) begin
        count_d = CNT_W'(1);
      end else if (32'(wval) > 32'(MAX_ROADS)) begin
        count_d = CNT_W'(MAX_ROADS);
      end else begin
        count_d = CNT_W'(wval);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(COUNT_RESET);
    end else begin
      count_q <= count_d;
    end
  end

  assign prdata = (paddr[2] == REG_ROAD_COUNT) ? APB_DATA_W'(count_q) : '0;

  assign cfg_o.reinit = wr_en;
  assign cfg_o.count  = count_q;

endmodule

>>> design/imhrl_ctrl.sv
// ----------------------------------------------------------------------------
// imhrl_ctrl
// Heap sequencer: root query, slot lookup, key lowering and sift-down over banked RAMs.
// ----------------------------------------------------------------------------
module imhrl_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  imhrl_pkg::cfg_t                 cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [imhrl_pkg::CMD_W-1:0]     command_i,
  input  logic [imhrl_pkg::ROAD_W-1:0]    road_i,
  input  logic [imhrl_pkg::HEIGHT_BITS-1:0] height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [imhrl_pkg::ROAD_W-1:0]    chosen_road_o
);
  import imhrl_pkg::*;

  state_e state_q, state_d;

  // Datapath registers
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [KEY_W-1:0]       cur_key_q, cur_key_d;
  logic [SLOT_W-1:0]      cur_road_q, cur_road_d;
  logic [HEIGHT_BITS-1:0] height_q, height_d;
  logic                   r_ok_q, r_ok_d;
  logic                   out_valid_q, out_valid_d;
  logic [ROAD_W-1:0]      chosen_q, chosen_d;

  // Valid bits: an entry never written reads as its reset value
  logic [2**SLOT_W-1:0] heap_vld_q;
  logic [2**SLOT_W-1:0] slot_vld_q;

  // Memory ports
  logic              heap_re;
  logic [ROW_W-1:0]  ev_raddr, od_raddr;
  logic              heap_we;
  logic [SLOT_W-1:0] heap_wslot;
  heap_ent_t         heap_wdata;
  logic [HEAP_W-1:0] ev_rdata, od_rdata;
  logic              sl_re;
  logic [SLOT_W-1:0] sl_raddr;
  logic              sl_we;
  logic [SLOT_W-1:0] sl_waddr;
  logic [SLOT_W-1:0] sl_wdata;
  logic [SLOT_W-1:0] sl_rdata;

  // Read tags, registered with the read
  logic [ROW_W-1:0]  ev_row_q, od_row_q;
  logic              ev_vld_q, od_vld_q;
  logic [SLOT_W-1:0] sl_addr_q;
  logic              sl_vld_q;

  heap_ent_t         ev_ent, od_ent, fetch_ent, best_ent;
  logic [SLOT_W-1:0] sl_slot;

  logic                  accept;
  logic                  is_query;
  logic                  road_ok;
  logic [ROAD_W-1:0]     road_m1;
  logic [KIDX_W-1:0]     l_idx, r_idx, count_kx;
  logic                  l_ok, r_ok;
  logic                  take_l, take_r, moving;
  logic [KEY_W-1:0]      best_key;
  logic [SLOT_W-1:0]     best_slot;
  logic [KEY_W-1:0]      height_ext;
  logic                  lower;
  logic                  slot_in_range;
  logic                  out_load;
  logic [SLOT_W:0]       root_p1;

  imhrl_ram #(.DATA_W(HEAP_W), .ADDR_W(ROW_W)) u_heap_even (
    .clk_i   (clk_i),
    .we_i    (heap_we && !heap_wslot[0]),
    .waddr_i (heap_wslot[SLOT_W-1:1]),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  imhrl_ram #(.DATA_W(HEAP_W), .ADDR_W(ROW_W)) u_heap_odd (
    .clk_i   (clk_i),
    .we_i    (heap_we && heap_wslot[0]),
    .waddr_i (heap_wslot[SLOT_W-1:1]),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  imhrl_ram #(.DATA_W(SLOT_W), .ADDR_W(SLOT_W)) u_road_slot (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (sl_re),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  // Resolve read data against the valid bits
  always_comb begin
    ev_ent = heap_ent_t'(ev_rdata);
    if (!ev_vld_q) begin
      ev_ent.key  = KEY_UNLIMITED;
      ev_ent.road = {ev_row_q, 1'b0};
    end
    od_ent = heap_ent_t'(od_rdata);
    if (!od_vld_q) begin
      od_ent.key  = KEY_UNLIMITED;
      od_ent.road = {od_row_q, 1'b1};
    end
  end

  assign sl_slot   = sl_vld_q ? sl_rdata : sl_addr_q;
  assign fetch_ent = idx_q[0] ? od_ent : ev_ent;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_query   = (command_i == CMD_QUERY);
  assign road_m1    = road_i - ROAD_W'(1);
  assign road_ok    = (road_i != '0) && (32'(road_i) <= 32'(cfg_i.count));

  assign height_ext    = {1'b0, height_q};
  assign lower         = fetch_ent.key > height_ext;
  assign slot_in_range = 32'(sl_slot) < 32'(cfg_i.count);

  // Children of idx: 2*idx+1 sits in the odd bank, 2*idx+2 in the even bank
  assign l_idx    = {1'b0, idx_q, 1'b1};
  assign r_idx    = l_idx + KIDX_W'(1);
  assign count_kx = KIDX_W'(cfg_i.count);
  assign l_ok     = l_idx < count_kx;
  assign r_ok     = r_idx < count_kx;

  // Left child tested first, strict compares
  assign take_l    = od_ent.key > cur_key_q;
  assign best_key  = take_l ? od_ent.key : cur_key_q;
  assign take_r    = r_ok_q && (ev_ent.key > best_key);
  assign moving    = take_l || take_r;
  assign best_ent  = take_r ? ev_ent : od_ent;
  assign best_slot = take_r ? {ev_row_q, 1'b0} : {od_row_q, 1'b1};

  assign out_load = (state_q == ST_QUERY) && (!out_valid_q || out_ready_i);
  assign root_p1  = {1'b0, ev_ent.road} + (SLOT_W+1)'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_query) begin
            state_d = ST_QUERY;
          end else if (road_ok) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_QUERY: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        state_d = slot_in_range ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        state_d = lower ? ST_KIDS : ST_IDLE;
      end
      ST_KIDS: begin
        state_d = l_ok ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        state_d = moving ? ST_KIDS : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath
  always_comb begin
    idx_d       = idx_q;
    cur_key_d   = cur_key_q;
    cur_road_d  = cur_road_q;
    height_d    = height_q;
    r_ok_d      = r_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    chosen_d    = chosen_q;
    heap_re     = 1'b0;
    ev_raddr    = '0;
    od_raddr    = '0;
    heap_we     = 1'b0;
    heap_wslot  = idx_q;
    heap_wdata  = heap_ent_t'{key: cur_key_q, road: cur_road_q};
    sl_re       = 1'b0;
    sl_raddr    = SLOT_W'(road_m1);
    sl_we       = 1'b0;
    sl_waddr    = cur_road_q;
    sl_wdata    = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          height_d   = height_i;
          cur_road_d = SLOT_W'(road_m1);
          if (is_query) begin
            heap_re = 1'b1;
          end else begin
            sl_re = road_ok;
          end
        end
      end
      ST_QUERY: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          chosen_d    = (height_ext < ev_ent.key) ? ROAD_W'(root_p1) : '0;
        end
      end
      ST_LOOKUP: begin
        idx_d    = sl_slot;
        heap_re  = slot_in_range;
        ev_raddr = sl_slot[SLOT_W-1:1];
        od_raddr = sl_slot[SLOT_W-1:1];
      end
      ST_FETCH: begin
        cur_key_d = height_ext;
      end
      ST_KIDS: begin
        if (l_ok) begin
          heap_re  = 1'b1;
          od_raddr = l_idx[ROW_W:1];
          ev_raddr = r_idx[ROW_W:1];
          r_ok_d   = r_ok;
        end else begin
          // Leaf reached: drop the floating entry here
          heap_we = 1'b1;
          sl_we   = 1'b1;
        end
      end
      ST_CMP: begin
        heap_we = 1'b1;
        sl_we   = 1'b1;
        if (moving) begin
          heap_wdata = best_ent;
          sl_waddr   = best_ent.road;
          idx_d      = best_slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      heap_vld_q  <= '0;
      slot_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.reinit) begin
        heap_vld_q <= '0;
        slot_vld_q <= '0;
      end else begin
        if (heap_we) begin
          heap_vld_q[heap_wslot] <= 1'b1;
        end
        if (sl_we) begin
          slot_vld_q[sl_waddr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cur_key_q  <= cur_key_d;
    cur_road_q <= cur_road_d;
    height_q   <= height_d;
    r_ok_q     <= r_ok_d;
    chosen_q   <= chosen_d;
    if (heap_re) begin
      ev_row_q <= ev_raddr;
      od_row_q <= od_raddr;
      ev_vld_q <= heap_vld_q[{ev_raddr, 1'b0}];
      od_vld_q <= heap_vld_q[{od_raddr, 1'b1}];
    end
    if (sl_re) begin
      sl_addr_q <= sl_raddr;
      sl_vld_q  <= slot_vld_q[sl_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_road_o = chosen_q;

`ifndef SYNTHESIS
  a_write_only_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_we || sl_we) |-> (state_q == ST_KIDS || state_q == ST_CMP))
    else $error("heap write outside sift-down");

  a_sift_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KIDS) |-> (32'(idx_q) < 32'(cfg_i.count)))
    else $error("sift index beyond road count");

  a_sift_moves_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && moving) |=> (idx_q > $past(idx_q)))
    else $error("sift-down did not descend");

  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.reinit |=> (heap_vld_q == '0 && slot_vld_q == '0))
    else $error("reinit left valid entries");

  a_query_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("query result not presented");
`endif

endmodule

>>> design/indexed_max_heap_of_route_limits_unit.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_of_route_limits_unit
// Per-road clearance limits kept in an indexed binary max-heap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries command_i, road_i and
//   height_i. An add transaction lowers the road's limit to height_i when it
//   is strictly smaller and sifts the entry down; it returns nothing. A query
//   transaction returns one output transaction with chosen_road_o: the road
//   at the heap root when height_i is strictly below its limit, else 0.
//   Sequencing: one transaction at a time. A query reads the heap root, then
//   loads its result into the output register, waiting while an earlier
//   result is still held. An add looks up the road's slot, reads the entry,
//   and, if lowered, repeats a children read and a compare and write-back
//   for each level the entry descends (at most 6 for 64 roads).
//   Output stall: the result sits in an output register, so a new
//   transaction is taken while it waits; a second query holds until the
//   receiver takes the first result.
//   Reset: all limits unlimited, slot i holds road i+1, road_count 64.
//   Writing road_count over APB (address 0) reinitializes the heap at once
//   through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_max_heap_of_route_limits_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imhrl_pkg::PADDR_W-1:0]     paddr,
  input  logic [imhrl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [imhrl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  // Command channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [imhrl_pkg::CMD_W-1:0]       command_i,
  input  logic [imhrl_pkg::ROAD_W-1:0]      road_i,
  input  logic [imhrl_pkg::HEIGHT_BITS-1:0] height_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [imhrl_pkg::ROAD_W-1:0]      chosen_road_o
);
  import imhrl_pkg::*;

  // Road count and reinit strobe from the register file
  cfg_t cfg;

  imhrl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer with the heap and slot RAMs
  imhrl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .road_i        (road_i),
    .height_i      (height_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .chosen_road_o (chosen_road_o)
  );

endmodule
